@@ rtl/psef_pkg.sv @@
// Shared types, constants and lookup functions for the PNG stream end finder.
// No dependencies; every other file in rtl uses this package.
`default_nettype none
package psef_pkg;

  // Width kept from the big-endian chunk length field.
  localparam int LENGTH_BITS  = 32;
  // Width of the chunk limit register and the header counter.
  localparam int LIMIT_W      = 17;
  // Width of the reported image length.
  localparam int PNG_LEN_W    = 32;
  // Byte counter width inside the signature or a chunk header.
  localparam int FIELD_W      = 4;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = LIMIT_W'(99999);
  localparam logic [FIELD_W-1:0]   SIG_LAST     = FIELD_W'(7);
  localparam logic [FIELD_W-1:0]   LEN_END      = FIELD_W'(4);
  localparam logic [FIELD_W-1:0]   TYPE_FIRST   = FIELD_W'(4);
  localparam logic [FIELD_W-1:0]   TYPE_END     = FIELD_W'(8);
  localparam logic [FIELD_W-1:0]   HEADER_LAST  = FIELD_W'(11);
  localparam int                   HEADER_BYTES = 12;

  // Largest chunk length whose length+12 does not wrap.
  localparam logic [LENGTH_BITS-1:0] WRAP_LIMIT =
      {LENGTH_BITS{1'b1}} - LENGTH_BITS'(HEADER_BYTES);

  typedef enum logic [1:0] {
    PH_SIG,
    PH_HEAD,
    PH_SKIP,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND,
    ST_NOT_PNG,
    ST_TRUNCATED,
    ST_LIMIT
  } status_t;

  // The 8-byte PNG signature.
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      3'd7:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // The chunk type "IEND".
  function automatic logic [7:0] end_type_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h49;
      2'd1:    b = 8'h45;
      2'd2:    b = 8'h4E;
      2'd3:    b = 8'h44;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/psef_if.sv @@
// Channel interfaces for the PNG stream end finder: byte input, result output
// and the chunk limit write channel. Depends on psef_pkg.
`default_nettype none
interface psef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface psef_out_if;
  logic                              valid;
  logic                              ready;
  psef_pkg::status_t                 status;
  logic [psef_pkg::PNG_LEN_W-1:0]    png_length;

  modport source (output valid, output status, output png_length, input ready);
  modport sink   (input valid, input status, input png_length, output ready);
endinterface

interface psef_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [psef_pkg::LIMIT_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/png_stream_end_finder.sv @@
// Throughput: one byte per cycle while the skid entry is empty; the chunk walker
// updates its state in one pass, and a full skid entry holds input ready low.
// A two-entry output (register plus skid) keeps input flowing while a result waits.
// Reset (rst_n low, synchronous) clears the search and sets chunk_limit to 99999.
// Depends on psef_pkg and the interfaces in psef_if.sv.
`default_nettype none
module png_stream_end_finder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psef_in_if.sink    in_chan,
  psef_out_if.source out_chan,
  psef_cfg_if.sink   cfg_chan
);

  localparam int LB = psef_pkg::LENGTH_BITS;
  localparam int PW = psef_pkg::PNG_LEN_W;

  // Search state.
  psef_pkg::phase_t                  phase_r, phase_nxt;
  logic [psef_pkg::FIELD_W-1:0]      bif_r, bif_nxt;
  logic [LB-1:0]                     chunk_len_r, chunk_len_nxt;
  logic                              type_end_r, type_end_nxt;
  logic [LB-1:0]                     skip_left_r, skip_left_nxt;
  logic [PW-1:0]                     total_r, total_nxt;
  logic [psef_pkg::LIMIT_W-1:0]      chunks_r, chunks_nxt;
  logic [psef_pkg::LIMIT_W-1:0]      chunk_limit_r;

  // Output register and skid entry.
  logic                              out_valid_r, skid_valid_r;
  psef_pkg::status_t                 out_status_r, skid_status_r;
  logic [PW-1:0]                     out_len_r, skid_len_r;

  logic                              accept;
  logic                              has_res;
  psef_pkg::status_t                 res_status;
  logic [PW-1:0]                     res_len;
  logic [PW-1:0]                     total_inc;
  logic                              type_hit;

  assign in_chan.ready  = !skid_valid_r;
  assign accept         = in_chan.valid && !skid_valid_r;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.png_length = out_len_r;

  assign total_inc = total_r + PW'(1);
  assign type_hit  = (in_chan.data_byte == psef_pkg::end_type_byte(bif_r[1:0]));

  // Next search state and result for the byte at the input.
  always_comb begin
    phase_nxt     = phase_r;
    bif_nxt       = bif_r;
    chunk_len_nxt = chunk_len_r;
    type_end_nxt  = type_end_r;
    skip_left_nxt = skip_left_r;
    total_nxt     = total_r;
    chunks_nxt    = chunks_r;
    has_res       = 1'b0;
    res_status    = psef_pkg::ST_FOUND;
    res_len       = '0;

    case (phase_r)
      psef_pkg::PH_SIG: begin
        total_nxt = total_inc;
        if (in_chan.data_byte != psef_pkg::sig_byte(bif_r[2:0])) begin
          has_res    = 1'b1;
          res_status = psef_pkg::ST_NOT_PNG;
        end else if (bif_r == psef_pkg::SIG_LAST) begin
          phase_nxt = psef_pkg::PH_HEAD;
          bif_nxt   = '0;
        end else begin
          bif_nxt = bif_r + psef_pkg::FIELD_W'(1);
        end
      end
      psef_pkg::PH_HEAD: begin
        total_nxt = total_inc;
        if (bif_r < psef_pkg::LEN_END) begin
          chunk_len_nxt = {chunk_len_r[LB-9:0], in_chan.data_byte};
        end else if (bif_r < psef_pkg::TYPE_END) begin
          type_end_nxt = (bif_r == psef_pkg::TYPE_FIRST) ? type_hit
                                                         : (type_end_r && type_hit);
        end
        bif_nxt = bif_r + psef_pkg::FIELD_W'(1);
        // The twelfth header byte decides the chunk.
        if (bif_r == psef_pkg::HEADER_LAST) begin
          if (chunks_r >= chunk_limit_r) begin
            has_res    = 1'b1;
            res_status = psef_pkg::ST_LIMIT;
          end else begin
            chunks_nxt = chunks_r + psef_pkg::LIMIT_W'(1);
            if (type_end_r) begin
              has_res    = 1'b1;
              res_status = psef_pkg::ST_FOUND;
              res_len    = total_inc;
            end else begin
              // A wrapped length+12 clamps to a bare header: nothing to skip.
              skip_left_nxt = (chunk_len_r > psef_pkg::WRAP_LIMIT) ? '0 : chunk_len_r;
              bif_nxt       = '0;
              chunk_len_nxt = '0;
              type_end_nxt  = 1'b0;
              phase_nxt     = (skip_left_nxt != '0) ? psef_pkg::PH_SKIP
                                                    : psef_pkg::PH_HEAD;
            end
          end
        end
      end
      psef_pkg::PH_SKIP: begin
        total_nxt     = total_inc;
        skip_left_nxt = skip_left_r - LB'(1);
        if (skip_left_r == LB'(1)) begin
          phase_nxt = psef_pkg::PH_HEAD;
        end
      end
      psef_pkg::PH_IDLE: begin
        // The search is over; bytes are dropped until the stream ends.
      end
      default: begin
      end
    endcase

    // Stream ended with no verdict yet.
    if (!has_res && in_chan.is_last && (phase_nxt != psef_pkg::PH_IDLE)) begin
      has_res    = 1'b1;
      res_status = (phase_nxt == psef_pkg::PH_SIG) ? psef_pkg::ST_NOT_PNG
                                                   : psef_pkg::ST_TRUNCATED;
    end

    if (has_res) begin
      phase_nxt = psef_pkg::PH_IDLE;
    end

    // End of stream starts a fresh search.
    if (in_chan.is_last) begin
      phase_nxt     = psef_pkg::PH_SIG;
      bif_nxt       = '0;
      chunk_len_nxt = '0;
      type_end_nxt  = 1'b0;
      skip_left_nxt = '0;
      total_nxt     = '0;
      chunks_nxt    = '0;
    end
  end

  // Search state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= psef_pkg::PH_SIG;
      bif_r       <= '0;
      chunk_len_r <= '0;
      type_end_r  <= 1'b0;
      skip_left_r <= '0;
      total_r     <= '0;
      chunks_r    <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      bif_r       <= bif_nxt;
      chunk_len_r <= chunk_len_nxt;
      type_end_r  <= type_end_nxt;
      skip_left_r <= skip_left_nxt;
      total_r     <= total_nxt;
      chunks_r    <= chunks_nxt;
    end
  end

  // Chunk limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_limit_r <= psef_pkg::LIMIT_RESET;
    end else if (cfg_chan.valid) begin
      chunk_limit_r <= cfg_chan.data;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && has_res;
      end
    end else if (accept && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_status_r <= skid_status_r;
        out_len_r    <= skid_len_r;
      end else begin
        out_status_r <= res_status;
        out_len_r    <= res_len;
      end
    end else if (accept && has_res) begin
      skid_status_r <= res_status;
      skid_len_r    <= res_len;
    end
  end

endmodule
`default_nettype wire

@@ rtl/psef_checker.sv @@
// Port-level assertions for the PNG stream end finder, bound to the top level.
// Depends on psef_pkg and on the top level's channel interfaces.
`default_nettype none
module psef_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [1:0]                     out_status,
  input wire logic [psef_pkg::PNG_LEN_W-1:0] out_png_length
);

  // A request that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  // Only a found image carries a length.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status != 2'(psef_pkg::ST_FOUND)) |-> out_png_length == '0)
    else $error("nonzero length on a result that is not a found image");

  // Input stalls only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
      !in_ready |-> out_valid)
    else $error("input stalled with the output empty");

  // Reset empties the output.
  a_reset_clear: assert property (@(posedge clk)
      !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind png_stream_end_finder psef_checker u_psef_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_png_length (out_chan.png_length)
);
`default_nettype wire

@@ sim/tb_png_stream_end_finder.sv @@
// Self-checking bench for png_stream_end_finder: feeds PNG-like byte streams,
// predicts the outcome of every search and compares it with the result channel.
// Depends on psef_pkg, the channel interfaces in rtl/psef_if.sv and the RTL top.
module tb_png_stream_end_finder;
  import psef_pkg::*;

  localparam logic [63:0] PNG_MAGIC       = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] IEND_TAG        = 32'h4945_4E44;
  localparam logic [31:0] IDAT_TAG        = 32'h4944_4154;
  localparam logic [31:0] TEXT_TAG        = 32'h7445_5874;
  localparam logic [31:0] ODD_TAG         = 32'h6162_6364;
  localparam logic [31:0] NEAR_IEND_TAG   = 32'h4945_4E78;
  localparam logic [31:0] WRAP_FIRST      = 32'hFFFF_FFF4;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};
  localparam int RANDOM_BYTES    = 540;
  localparam int RANDOM_VERDICTS = 20;
  localparam int SETTLE_CYCLES   = 3;
  localparam int TAIL_CYCLES     = 8;

  typedef struct packed {
    status_t              st;
    logic [PNG_LEN_W-1:0] plen;
  } verdict_t;

  typedef enum {OP_BYTE, OP_SIG, OP_HDR, OP_FILL, OP_LIMIT} op_t;

  typedef struct {
    op_t         op;
    logic [31:0] arg;
    logic [31:0] tag;
    bit          last;
    bit          typed;
    verdict_t    want;
  } step_t;

  logic clk;
  logic rst_n;

  psef_in_if  in_ch();
  psef_out_if out_ch();
  psef_cfg_if cfg_ch();

  png_stream_end_finder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch),
    .cfg_chan(cfg_ch)
  );

  // Chunk walker state kept by the bench.
  phase_t             w_phase;
  logic [3:0]         w_pos;
  logic [31:0]        w_len;
  bit                 w_iend;
  logic [32:0]        w_skip;
  logic [31:0]        w_used;
  logic [LIMIT_W-1:0] w_headers;
  logic [LIMIT_W-1:0] w_limit;

  verdict_t    verdicts_due[$];
  step_t       plan[$];
  logic [7:0]  stream_bytes[$];
  bit          typed_on;
  verdict_t    typed_want;
  int          send_calm;
  int          recv_calm;
  int          errors;
  int          n_bytes;
  int          n_streams;
  int          n_predicted;
  int          n_results;
  int          n_limits;
  int          status_tally[4];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap before the next request; now and then a run of back-to-back requests.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic void clear_walk();
    w_phase   = PH_SIG;
    w_pos     = '0;
    w_len     = '0;
    w_iend    = 1'b0;
    w_skip    = '0;
    w_used    = '0;
    w_headers = '0;
  endfunction

  // Advance the chunk walker by one byte and report whether a search ended.
  function automatic void walk_png_byte(input logic [7:0] d, input bit last,
                                        output bit hit, output verdict_t v);
    logic [31:0] span;
    bit          tag_ok;
    hit    = 1'b0;
    v.st   = ST_FOUND;
    v.plen = '0;
    if (w_phase != PH_IDLE) w_used = w_used + 1;
    case (w_phase)
      PH_SIG: begin
        if (d != PNG_MAGIC[63 - 8*w_pos[2:0] -: 8]) begin
          hit  = 1'b1;
          v.st = ST_NOT_PNG;
        end else if (w_pos == 4'd7) begin
          w_phase = PH_HEAD;
          w_pos   = '0;
        end else begin
          w_pos = w_pos + 4'd1;
        end
      end
      PH_HEAD: begin
        if (w_pos < 4) begin
          w_len = {w_len[23:0], d};
        end else if (w_pos < 8) begin
          tag_ok = (d == IEND_TAG[31 - 8*(w_pos - 4) -: 8]);
          w_iend = (w_pos == 4) ? tag_ok : (w_iend && tag_ok);
        end
        if (w_pos != 4'd11) begin
          w_pos = w_pos + 4'd1;
        end else if (w_headers >= w_limit) begin
          hit  = 1'b1;
          v.st = ST_LIMIT;
        end else begin
          w_headers = w_headers + LIMIT_W'(1);
          if (w_iend) begin
            hit    = 1'b1;
            v.plen = w_used;
          end else begin
            // A length whose sum with the header size wraps skips nothing.
            span = w_len + 32'd12;
            if (span < 32'd12) span = 32'd12;
            w_skip  = {1'b0, span - 32'd12};
            w_pos   = '0;
            w_len   = '0;
            w_iend  = 1'b0;
            w_phase = (w_skip != 0) ? PH_SKIP : PH_HEAD;
          end
        end
      end
      PH_SKIP: begin
        w_skip = w_skip - 1;
        if (w_skip == 0) w_phase = PH_HEAD;
      end
      default: ;
    endcase
    if (!hit && last && w_phase != PH_IDLE) begin
      hit  = 1'b1;
      v.st = (w_phase == PH_SIG) ? ST_NOT_PNG : ST_TRUNCATED;
    end
    if (hit) w_phase = PH_IDLE;
    if (last) clear_walk();
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_bytes = {stream_bytes, w[31 - 8*i -: 8]};
  endfunction

  function automatic void put_random(input int n);
    repeat (n) stream_bytes = {stream_bytes, 8'($urandom_range(0, 255))};
  endfunction

  function automatic void put_signature();
    put_word(PNG_MAGIC[63:32]);
    put_word(PNG_MAGIC[31:0]);
  endfunction

  // Length, type and the four bytes that close the 12-byte header.
  function automatic void put_header(input logic [31:0] len, input logic [31:0] tag);
    put_word(len);
    put_word(tag);
    put_random(4);
  endfunction

  function automatic void add_step(input op_t op, input logic [31:0] arg,
                                   input logic [31:0] tag, input bit last,
                                   input bit typed, input status_t st,
                                   input logic [31:0] plen);
    step_t s;
    s.op        = op;
    s.arg       = arg;
    s.tag       = tag;
    s.last      = last;
    s.typed     = typed;
    s.want.st   = st;
    s.want.plen = plen;
    plan = {plan, s};
  endfunction

  // One byte request; called at a falling edge and returns at one.
  task automatic send_byte(input logic [7:0] d, input bit last);
    int       gap;
    bit       hit;
    verdict_t v;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.is_last   <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    walk_png_byte(d, last, hit, v);
    if (hit) begin
      verdicts_due = {verdicts_due, (typed_on ? typed_want : v)};
      n_predicted++;
    end
    n_bytes++;
    if (last) n_streams++;
    @(negedge clk);
  endtask

  task automatic send_stream(input int stop);
    for (int i = 0; i <= stop; i++) send_byte(stream_bytes[i], i == stop);
  endtask

  // The limit is written only once every pending result has been received.
  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lim;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    w_limit = lim;
    n_limits++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_row(input step_t s);
    typed_on   = s.typed;
    typed_want = s.want;
    stream_bytes.delete();
    case (s.op)
      OP_LIMIT: write_limit(s.arg[LIMIT_W-1:0]);
      OP_BYTE:  stream_bytes = {stream_bytes, s.arg[7:0]};
      OP_SIG:   put_signature();
      OP_HDR:   put_header(s.arg, s.tag);
      OP_FILL:  put_random(s.arg);
      default:  ;
    endcase
    foreach (stream_bytes[i])
      send_byte(stream_bytes[i], s.last && i == stream_bytes.size() - 1);
  endtask

  // Mostly well-formed images with random content, some cut short or broken.
  task automatic random_stream();
    int          stop;
    logic [31:0] len;
    logic [31:0] tag;
    stream_bytes.delete();
    if ($urandom_range(0, 5) == 0) begin
      put_random($urandom_range(1, 6));
    end else begin
      put_signature();
      if ($urandom_range(0, 7) == 0)
        stream_bytes[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 9) < 8) len = $urandom_range(0, 6);
        else len = WRAP_FIRST + $urandom_range(0, 11);
        if ($urandom_range(0, 2) == 0) tag = IEND_TAG ^ (32'd1 << $urandom_range(0, 31));
        else tag = $urandom;
        put_header(len, tag);
        if (len < WRAP_FIRST) put_random(len);
      end
      if ($urandom_range(0, 7) != 0) put_header($urandom, IEND_TAG);
      put_random($urandom_range(0, 2));
    end
    stop = stream_bytes.size() - 1;
    if ($urandom_range(0, 4) == 0) stop = $urandom_range(0, stop);
    send_stream(stop);
  endtask

  task automatic maybe_new_limit();
    int pick;
    if ($urandom_range(0, 5) != 0) return;
    pick = $urandom_range(0, 6);
    case (pick)
      4:       write_limit(LIMIT_W'($urandom_range(1, 131071)));
      5:       write_limit(LIMIT_MAX);
      6:       write_limit(LIMIT_RESET);
      default: write_limit(LIMIT_W'(pick + 1));
    endcase
  endtask

  // Result sink with its own random stalls.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      @(negedge clk);
    end
  end

  // Compare each received result with the oldest expected one.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      status_tally[out_ch.status]++;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d length %0d", $time,
                 out_ch.status, out_ch.png_length);
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.status !== want.st) begin
          errors++;
          $display("%0t: status expected %0d, actual %0d", $time, want.st,
                   out_ch.status);
        end
        if (out_ch.png_length !== want.plen) begin
          errors++;
          $display("%0t: png_length expected %0d, actual %0d", $time, want.plen,
                   out_ch.png_length);
        end
      end
    end
  end

  // Stimulus: directed rows, then random streams.
  initial begin
    int start_bytes;
    int start_pred;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.is_last   = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    w_limit         = LIMIT_RESET;
    clear_walk();

    // Bad first byte, then a byte ignored until the end of the stream.
    add_step(OP_BYTE, 32'h00, '0, 1'b0, 1'b1, ST_NOT_PNG, 0);
    add_step(OP_BYTE, 32'hFF, '0, 1'b1, 1'b0, ST_FOUND, 0);
    // Stream ends inside the signature, then right after it.
    add_step(OP_BYTE, 32'h89, '0, 1'b1, 1'b1, ST_NOT_PNG, 0);
    add_step(OP_SIG, '0, '0, 1'b1, 1'b1, ST_TRUNCATED, 0);
    // Smallest image: signature and an empty IEND chunk.
    add_step(OP_SIG, '0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, IEND_TAG, 1'b0, 1'b1, ST_FOUND, 20);
    add_step(OP_BYTE, 32'h00, '0, 1'b1, 1'b0, ST_FOUND, 0);
    // Wrapping lengths, a near miss on the IEND type, a skipped body and an
    // IEND whose length field is ignored.
    add_step(OP_SIG, '0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, 32'hFFFF_FFFF, IDAT_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, WRAP_FIRST, NEAR_IEND_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, 32'd5, TEXT_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_FILL, 32'd5, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, 32'h1234_5678, IEND_TAG, 1'b1, 1'b0, ST_FOUND, 0);
    // A limit of zero stops at the first header.
    add_step(OP_LIMIT, 32'd0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_SIG, '0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, IEND_TAG, 1'b1, 1'b1, ST_LIMIT, 0);
    // A limit of one stops at the second header.
    add_step(OP_LIMIT, 32'd1, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_SIG, '0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, IDAT_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, IEND_TAG, 1'b1, 1'b1, ST_LIMIT, 0);
    // Largest limit; the stream ends while a chunk body is skipped.
    add_step(OP_LIMIT, LIMIT_MAX, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_SIG, '0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, 32'd2, IDAT_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_FILL, 32'd2, '0, 1'b1, 1'b1, ST_TRUNCATED, 0);
    // Limit lowered below the count in the middle of a search.
    add_step(OP_LIMIT, LIMIT_RESET, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_SIG, '0, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, ODD_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, ODD_TAG, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_LIMIT, 32'd1, '0, 1'b0, 1'b0, ST_FOUND, 0);
    add_step(OP_HDR, '0, IEND_TAG, 1'b1, 1'b1, ST_LIMIT, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) run_row(plan[i]);
    typed_on = 1'b0;

    start_bytes = n_bytes;
    start_pred  = n_predicted;
    write_limit(LIMIT_RESET);
    while (n_bytes - start_bytes < RANDOM_BYTES ||
           n_predicted - start_pred < RANDOM_VERDICTS) begin
      maybe_new_limit();
      random_stream();
    end

    // Drain, then give the block time to show any stray result.
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d bytes in %0d streams with %0d limit writes; %0d results checked.",
             n_bytes, n_streams, n_limits, n_results);
    $display("Results by kind: found %0d, not png %0d, truncated %0d, limit %0d.",
             status_tally[ST_FOUND], status_tally[ST_NOT_PNG],
             status_tally[ST_TRUNCATED], status_tally[ST_LIMIT]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", verdicts_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
